// ===== hw/rtl/ffha_pkg.sv =====
package ffha_pkg;

  localparam int HEAP_SIZE_DEF   = 512;
  localparam int HEADER_SIZE_DEF = 12;
  localparam int OFF_W           = 9;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_LOAD_ALLOC,
    CMD_LOAD_FREE,
    CMD_RD_LOC,
    CMD_NEXT,
    CMD_NOFIT,
    CMD_TAKE,
    CMD_SPLIT,
    CMD_WR_TAIL,
    CMD_RD_AUX,
    CMD_WR_AUX,
    CMD_FREE_MARK,
    CMD_RD_PREV,
    CMD_MERGE_PREV,
    CMD_RD_NXT,
    CMD_MERGE_NXT,
    CMD_WR_LINK,
    CMD_POST
  } cmd_t;

  typedef struct packed {
    logic loc_in;
    logic fit_exact;
    logic fit_split;
    logic aux_in;
    logic prev_ok;
    logic rd_free;
    logic nxt_in;
  } dp_stat_t;

endpackage

// ===== hw/rtl/ffha_dp.sv =====
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_SIZE   = HEAP_SIZE_DEF,
  parameter int HEADER_SIZE = HEADER_SIZE_DEF
) (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [OFF_W-1:0] request_size,
  input  logic [OFF_W-1:0] free_address,
  output dp_stat_t         stat,
  output logic             status,
  output logic [OFF_W-1:0] payload_offset
);

  localparam int W  = $clog2(HEAP_SIZE);
  localparam int EW = ((W > OFF_W) ? W : OFF_W) + 2;
  localparam int MW = 2 * W + 1;

  localparam logic [EW-1:0] HDR       = EW'(HEADER_SIZE);
  localparam logic [EW-1:0] HEAP      = EW'(HEAP_SIZE);
  localparam logic [W-1:0]  INIT_SIZE = W'(HEAP_SIZE - HEADER_SIZE);

  logic [MW-1:0] mem [HEAP_SIZE];
  logic [MW-1:0] rdata;

  logic          we;
  logic [W-1:0]  waddr;
  logic [MW-1:0] wdata;
  logic          re;
  logic [W-1:0]  raddr;

  logic [EW-1:0]    loc;
  logic [OFF_W-1:0] req;
  logic [W-1:0]     cur_prior;
  logic [W-1:0]     cur_size;
  logic [EW-1:0]    tail;
  logic [EW-1:0]    after;
  logic [W-1:0]     rest;
  logic             pend_status;
  logic [OFF_W-1:0] pend_offset;

  logic          rd_free;
  logic [W-1:0]  rd_prior;
  logic [W-1:0]  rd_size;
  logic [EW-1:0] size_ext;
  logic [EW-1:0] req_ext;
  logic [EW-1:0] loc_step;
  logic [EW-1:0] off_sum;
  logic [EW-1:0] nxt;
  logic [EW-1:0] prev_back;
  logic [EW-1:0] prev_at;
  logic [EW-1:0] merged_sum;
  logic [W-1:0]  merged;
  logic          tail_in;

  assign rd_free  = rdata[MW-1];
  assign rd_prior = rdata[MW-2:W];
  assign rd_size  = rdata[W-1:0];

  assign size_ext   = EW'(rd_size);
  assign req_ext    = EW'(req);
  assign loc_step   = loc + size_ext + HDR;
  assign off_sum    = loc + HDR;
  assign nxt        = loc + HDR + EW'(cur_size);
  assign prev_back  = EW'(cur_prior) + HDR;
  assign prev_at    = loc - prev_back;
  assign merged_sum = size_ext + EW'(cur_size) + HDR;
  assign merged     = merged_sum[W-1:0];
  assign tail_in    = tail < HEAP;

  assign stat.loc_in    = loc < HEAP;
  assign stat.fit_exact = rd_free && (size_ext == req_ext);
  assign stat.fit_split = rd_free && (size_ext >= req_ext + HDR);
  assign stat.aux_in    = after < HEAP;
  assign stat.prev_ok   = (loc != '0) && (prev_back <= loc);
  assign stat.rd_free   = rd_free;
  assign stat.nxt_in    = nxt < HEAP;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = loc[W-1:0];
    wdata = '0;
    re    = 1'b0;
    raddr = loc[W-1:0];
    case (cmd)
      CMD_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, {W{1'b0}}, INIT_SIZE};
      end
      CMD_RD_LOC: begin
        re = 1'b1;
      end
      CMD_TAKE: begin
        we    = 1'b1;
        wdata = {1'b0, rd_prior, rd_size};
      end
      CMD_SPLIT: begin
        we    = 1'b1;
        wdata = {1'b0, rd_prior, req_ext[W-1:0]};
      end
      CMD_WR_TAIL: begin
        we    = tail_in;
        waddr = tail[W-1:0];
        wdata = {1'b1, req_ext[W-1:0], rest};
      end
      CMD_RD_AUX: begin
        re    = 1'b1;
        raddr = after[W-1:0];
      end
      CMD_WR_AUX: begin
        we    = 1'b1;
        waddr = after[W-1:0];
        wdata = {rd_free, rest, rd_size};
      end
      CMD_FREE_MARK: begin
        we    = 1'b1;
        wdata = {1'b1, rd_prior, rd_size};
      end
      CMD_RD_PREV: begin
        re    = 1'b1;
        raddr = prev_at[W-1:0];
      end
      CMD_MERGE_PREV: begin
        we    = 1'b1;
        waddr = prev_at[W-1:0];
        wdata = {rd_free, rd_prior, merged};
      end
      CMD_RD_NXT: begin
        re    = 1'b1;
        raddr = nxt[W-1:0];
      end
      CMD_MERGE_NXT: begin
        we    = 1'b1;
        wdata = {1'b1, cur_prior, merged};
      end
      CMD_WR_LINK: begin
        we    = 1'b1;
        waddr = nxt[W-1:0];
        wdata = {rd_free, cur_size, rd_size};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // header store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD_ALLOC: begin
        loc <= '0;
        req <= request_size;
      end
      CMD_LOAD_FREE: begin
        // below the header size this wraps far past the heap end
        loc         <= EW'(free_address) - HDR;
        pend_status <= ST_DONE;
        pend_offset <= '0;
      end
      CMD_NEXT: begin
        loc <= loc_step;
      end
      CMD_NOFIT: begin
        pend_status <= ST_NOFIT;
        pend_offset <= '0;
      end
      CMD_TAKE: begin
        pend_status <= ST_DONE;
        pend_offset <= off_sum[OFF_W-1:0];
      end
      CMD_SPLIT: begin
        pend_status <= ST_DONE;
        pend_offset <= off_sum[OFF_W-1:0];
        tail        <= loc + req_ext + HDR;
        after       <= loc_step;
        rest        <= W'(size_ext - req_ext - HDR);
      end
      CMD_FREE_MARK: begin
        cur_prior <= rd_prior;
        cur_size  <= rd_size;
      end
      CMD_MERGE_PREV: begin
        loc       <= prev_at;
        cur_prior <= rd_prior;
        cur_size  <= merged;
      end
      CMD_MERGE_NXT: begin
        cur_size <= merged;
      end
      CMD_POST: begin
        status         <= pend_status;
        payload_offset <= pend_offset;
      end
      default: begin
        loc <= loc;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     opcode,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_EVAL,
    S_A_TAIL,
    S_A_RDAFT,
    S_A_WRAFT,
    S_F_RD,
    S_F_MARK,
    S_F_CHKPREV,
    S_F_PREV,
    S_F_CHKNXT,
    S_F_NXT,
    S_F_CHKLINK,
    S_F_LINK,
    S_POST
  } state_t;

  state_t state;
  state_t state_next;
  logic   post;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    post       = 1'b0;
    case (state)
      S_INIT: begin
        cmd        = CMD_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OPC_FREE) begin
            cmd        = CMD_LOAD_FREE;
            state_next = S_F_RD;
          end else begin
            cmd        = CMD_LOAD_ALLOC;
            state_next = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        if (stat.loc_in) begin
          cmd        = CMD_RD_LOC;
          state_next = S_A_EVAL;
        end else begin
          cmd        = CMD_NOFIT;
          state_next = S_POST;
        end
      end
      S_A_EVAL: begin
        if (stat.fit_exact) begin
          cmd        = CMD_TAKE;
          state_next = S_POST;
        end else if (stat.fit_split) begin
          cmd        = CMD_SPLIT;
          state_next = S_A_TAIL;
        end else begin
          cmd        = CMD_NEXT;
          state_next = S_A_RD;
        end
      end
      S_A_TAIL: begin
        cmd        = CMD_WR_TAIL;
        state_next = stat.aux_in ? S_A_RDAFT : S_POST;
      end
      S_A_RDAFT: begin
        cmd        = CMD_RD_AUX;
        state_next = S_A_WRAFT;
      end
      S_A_WRAFT: begin
        cmd        = CMD_WR_AUX;
        state_next = S_POST;
      end
      S_F_RD: begin
        if (stat.loc_in) begin
          cmd        = CMD_RD_LOC;
          state_next = S_F_MARK;
        end else begin
          state_next = S_POST;
        end
      end
      S_F_MARK: begin
        cmd        = CMD_FREE_MARK;
        state_next = S_F_CHKPREV;
      end
      S_F_CHKPREV: begin
        if (stat.prev_ok) begin
          cmd        = CMD_RD_PREV;
          state_next = S_F_PREV;
        end else begin
          state_next = S_F_CHKNXT;
        end
      end
      S_F_PREV: begin
        if (stat.rd_free) begin
          cmd = CMD_MERGE_PREV;
        end
        state_next = S_F_CHKNXT;
      end
      S_F_CHKNXT: begin
        if (stat.nxt_in) begin
          cmd        = CMD_RD_NXT;
          state_next = S_F_NXT;
        end else begin
          state_next = S_POST;
        end
      end
      S_F_NXT: begin
        if (stat.rd_free) begin
          cmd = CMD_MERGE_NXT;
        end
        state_next = S_F_CHKLINK;
      end
      S_F_CHKLINK: begin
        if (stat.nxt_in) begin
          cmd        = CMD_RD_NXT;
          state_next = S_F_LINK;
        end else begin
          state_next = S_POST;
        end
      end
      S_F_LINK: begin
        cmd        = CMD_WR_LINK;
        state_next = S_POST;
      end
      S_POST: begin
        if (!out_valid || !out_stall) begin
          cmd        = CMD_POST;
          post       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (post) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator with boundary tags over HEAP_SIZE byte offsets, one
// header per block kept in a single-port-write, single-port-read header memory.
// Each accepted beat gives exactly one result beat. After reset the block writes
// the initial free header before it accepts its first beat. After the accepting
// edge an allocate walks the block headers first-fit, one header read per memory
// access, then on a split writes the tail header and fixes the following
// back-link, and then posts the result. A free marks the block, merges a free
// neighbour on each side, fixes the following back-link and posts; an ignored
// free posts at once. A new beat is taken only once the previous result sits in
// the output register, in the idle cycle after the post.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int HEAP_SIZE   = HEAP_SIZE_DEF,
  parameter int HEADER_SIZE = HEADER_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             opcode,
  input  logic [OFF_W-1:0] request_size,
  input  logic [OFF_W-1:0] free_address,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             status,
  output logic [OFF_W-1:0] payload_offset
);

  cmd_t     cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffha_dp #(
    .HEAP_SIZE   (HEAP_SIZE),
    .HEADER_SIZE (HEADER_SIZE)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .request_size   (request_size),
    .free_address   (free_address),
    .stat           (stat),
    .status         (status),
    .payload_offset (payload_offset)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import ffha_pkg::*;

  localparam int HEAP_BYTES = HEAP_SIZE_DEF;
  localparam int HDR_BYTES  = HEADER_SIZE_DEF;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 1325;
  localparam int DRAIN_CYC  = 100;

  typedef struct packed {
    logic             op;
    logic [OFF_W-1:0] req;
    logic [OFF_W-1:0] addr;
  } beat_t;

  typedef struct packed {
    logic             st;
    logic [OFF_W-1:0] off;
  } reply_t;

  typedef struct packed {
    logic             free;
    logic [OFF_W-1:0] prior;
    logic [OFF_W-1:0] size;
  } tag_t;

  typedef struct packed {
    logic             op;
    logic [OFF_W-1:0] req;
    logic [OFF_W-1:0] addr;
    logic             typed;
    logic             st;
    logic [OFF_W-1:0] off;
  } row_t;

  // op, request_size, free_address, typed, status, payload_offset
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{OPC_ALLOC, 9'd500, 9'd0,   1'b1, ST_DONE,  9'd12}, // whole heap, exact fit
    '{OPC_ALLOC, 9'd0,   9'd511, 1'b1, ST_NOFIT, 9'd0},  // heap full
    '{OPC_FREE,  9'd511, 9'd12,  1'b1, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd511, 9'd0,   1'b1, ST_NOFIT, 9'd0},
    '{OPC_ALLOC, 9'd501, 9'd0,   1'b1, ST_NOFIT, 9'd0},
    '{OPC_ALLOC, 9'd489, 9'd0,   1'b1, ST_NOFIT, 9'd0},  // too big to split, not exact
    '{OPC_ALLOC, 9'd488, 9'd0,   1'b1, ST_DONE,  9'd12}, // split, empty tail
    '{OPC_ALLOC, 9'd0,   9'd0,   1'b1, ST_DONE,  9'd0},  // tail taken, offset wraps
    '{OPC_ALLOC, 9'd0,   9'd0,   1'b1, ST_NOFIT, 9'd0},  // walk runs off heap end
    '{OPC_FREE,  9'd0,   9'd0,   1'b1, ST_DONE,  9'd0},  // below header, ignored
    '{OPC_FREE,  9'd0,   9'd11,  1'b1, ST_DONE,  9'd0},
    '{OPC_FREE,  9'd0,   9'd12,  1'b1, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd100, 9'd0,   1'b0, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd50,  9'd0,   1'b0, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd20,  9'd0,   1'b0, ST_DONE,  9'd0},
    '{OPC_FREE,  9'd0,   9'd124, 1'b0, ST_DONE,  9'd0},
    '{OPC_FREE,  9'd0,   9'd186, 1'b0, ST_DONE,  9'd0},  // merges both neighbors
    '{OPC_FREE,  9'd0,   9'd12,  1'b0, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd488, 9'd0,   1'b0, ST_DONE,  9'd0},
    '{OPC_FREE,  9'd0,   9'd12,  1'b0, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd30,  9'd0,   1'b0, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd40,  9'd0,   1'b0, ST_DONE,  9'd0},
    '{OPC_FREE,  9'd0,   9'd12,  1'b0, ST_DONE,  9'd0},
    '{OPC_ALLOC, 9'd40,  9'd0,   1'b0, ST_DONE,  9'd0},  // skips a small free block
    '{OPC_ALLOC, 9'd30,  9'd0,   1'b0, ST_DONE,  9'd0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             opcode = OPC_ALLOC;
  logic [OFF_W-1:0] request_size = '0;
  logic [OFF_W-1:0] free_address = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             status;
  logic [OFF_W-1:0] payload_offset;

  tag_t             hdr_tags [HEAP_BYTES];
  bit               hdr_written [HEAP_BYTES];
  bit               hit_unwritten;
  reply_t           reply_q [$];
  logic [OFF_W-1:0] live_blocks [$];
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  int               mismatches = 0;
  int               replies_seen = 0;
  int               n_alloc = 0, n_nofit = 0, n_free = 0, n_ignored = 0, n_stale = 0;

  first_fit_heap_allocator_top #(
    .HEAP_SIZE  (HEAP_BYTES),
    .HEADER_SIZE(HDR_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .request_size  (request_size),
    .free_address  (free_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_offset(payload_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void heap_reset();
    for (int i = 0; i < HEAP_BYTES; i++) begin
      hdr_tags[i] = '0;
      hdr_written[i] = 1'b0;
    end
    hdr_tags[0].free = 1'b1;
    hdr_tags[0].size = OFF_W'(HEAP_BYTES - HDR_BYTES);
    hdr_written[0] = 1'b1;
  endfunction

  function automatic tag_t read_tag(int at);
    if (!hdr_written[at]) hit_unwritten = 1'b1;
    return hdr_tags[at];
  endfunction

  // size and link updates are read-modify-write on an existing header
  function automatic void put_size(int at, int v);
    if (at < HEAP_BYTES) begin
      if (!hdr_written[at]) hit_unwritten = 1'b1;
      hdr_tags[at].size = v[OFF_W-1:0];
      hdr_written[at] = 1'b1;
    end
  endfunction

  function automatic void put_prior(int at, int v);
    if (at < HEAP_BYTES) begin
      if (!hdr_written[at]) hit_unwritten = 1'b1;
      hdr_tags[at].prior = v[OFF_W-1:0];
      hdr_written[at] = 1'b1;
    end
  endfunction

  function automatic reply_t heap_alloc(int n);
    int     loc, sz, tail, rest, after, pay;
    tag_t   t;
    reply_t r;
    loc = 0;
    while (loc < HEAP_BYTES) begin
      t = read_tag(loc);
      sz = int'(t.size);
      pay = loc + HDR_BYTES;
      if (t.free && sz == n) begin
        hdr_tags[loc].free = 1'b0;
        r.st = ST_DONE;
        r.off = pay[OFF_W-1:0];
        return r;
      end
      if (t.free && sz >= n + HDR_BYTES) begin
        tail = loc + n + HDR_BYTES;
        rest = sz - n - HDR_BYTES;
        after = loc + sz + HDR_BYTES;
        hdr_tags[loc].free = 1'b0;
        put_size(loc, n);
        if (tail < HEAP_BYTES) begin
          hdr_tags[tail].free = 1'b1;
          hdr_tags[tail].prior = n[OFF_W-1:0];
          hdr_tags[tail].size = rest[OFF_W-1:0];
          hdr_written[tail] = 1'b1;
        end
        if (after < HEAP_BYTES) put_prior(after, rest);
        r.st = ST_DONE;
        r.off = pay[OFF_W-1:0];
        return r;
      end
      loc += sz + HDR_BYTES;
    end
    r.st = ST_NOFIT;
    r.off = '0;
    return r;
  endfunction

  function automatic void heap_release(int addr);
    int   loc, back, p, nxt;
    tag_t t, pt, nt;
    if (addr < HDR_BYTES) return;
    loc = addr - HDR_BYTES;
    if (loc >= HEAP_BYTES) return;
    t = read_tag(loc);
    hdr_tags[loc].free = 1'b1;
    if (loc != 0) begin
      back = int'(t.prior) + HDR_BYTES;
      if (back <= loc) begin
        p = loc - back;
        pt = read_tag(p);
        if (pt.free) begin
          put_size(p, int'(pt.size) + int'(hdr_tags[loc].size) + HDR_BYTES);
          loc = p;
        end
      end
    end
    nxt = loc + HDR_BYTES + int'(hdr_tags[loc].size);
    if (nxt < HEAP_BYTES) begin
      nt = read_tag(nxt);
      if (nt.free) put_size(loc, int'(hdr_tags[loc].size) + HDR_BYTES + int'(nt.size));
    end
    nxt = loc + HDR_BYTES + int'(hdr_tags[loc].size);
    if (nxt < HEAP_BYTES) put_prior(nxt, int'(hdr_tags[loc].size));
  endfunction

  function automatic reply_t predict_reply(beat_t b);
    reply_t r;
    if (b.op == OPC_ALLOC) return heap_alloc(int'(b.req));
    heap_release(int'(b.addr));
    r.st = ST_DONE;
    r.off = '0;
    return r;
  endfunction

  // applies the beat to the heap image unless it would read a header never written
  function automatic bit try_beat(input beat_t b, output reply_t r);
    tag_t saved_tags [HEAP_BYTES];
    bit   saved_written [HEAP_BYTES];
    saved_tags = hdr_tags;
    saved_written = hdr_written;
    hit_unwritten = 1'b0;
    r = predict_reply(b);
    if (hit_unwritten) begin
      hdr_tags = saved_tags;
      hdr_written = saved_written;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void note_beat(beat_t b, reply_t r);
    if (b.op == OPC_ALLOC) begin
      n_alloc++;
      if (r.st == ST_NOFIT) n_nofit++;
      else if (r.off >= HDR_BYTES) live_blocks.push_back(r.off);
    end else if (b.addr < HDR_BYTES) begin
      n_ignored++;
    end else begin
      n_free++;
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == b.addr) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on beat %0d: %s expected %0d got %0d", replies_seen, what, want, got);
  endfunction

  task automatic send_beat(beat_t b, reply_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= b.op;
    request_size <= b.req;
    free_address <= b.addr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    reply_q.push_back(r);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (reply_q.size() == 0) begin
          note_mismatch("unexpected beat, status", 0, int'(status));
        end else begin
          want = reply_q.pop_front();
          if (status !== want.st) note_mismatch("status", int'(want.st), int'(status));
          if (payload_offset !== want.off)
            note_mismatch("payload_offset", int'(want.off), int'(payload_offset));
        end
        replies_seen++;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    beat_t  b;
    reply_t r;
    bit     ok;
    int     useful, roll, sel, free_pct;
    heap_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      b.op = DIRECTED[i].op;
      b.req = DIRECTED[i].req;
      b.addr = DIRECTED[i].addr;
      ok = try_beat(b, r);
      if (DIRECTED[i].typed) begin
        r.st = DIRECTED[i].st;
        r.off = DIRECTED[i].off;
      end
      note_beat(b, r);
      send_beat(b, r);
    end

    useful = 0;
    while (useful < N_RANDOM) begin
      idle_on = (useful < N_RANDOM - 150) && (useful % 200 < 150);
      do begin
        roll = $urandom_range(0, 99);
        b.req = OFF_W'($urandom);
        b.addr = OFF_W'($urandom);
        free_pct = (live_blocks.size() > 10) ? 65 : 40;
        if (live_blocks.size() > 0 && roll < free_pct) begin
          b.op = OPC_FREE;
          b.addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        end else if (roll >= 90 && roll < 93) begin
          b.op = OPC_FREE;
          b.addr = OFF_W'($urandom_range(0, HDR_BYTES - 1));
        end else if (roll >= 93 && roll < 97 && useful >= N_RANDOM - 300) begin
          // stale or double free late in the run
          b.op = OPC_FREE;
          b.addr = OFF_W'($urandom_range(HDR_BYTES, 2**OFF_W - 1));
          n_stale++;
        end else begin
          b.op = OPC_ALLOC;
          sel = $urandom_range(0, 9);
          if (sel == 0) b.req = '0;
          else if (sel == 1) b.req = OFF_W'($urandom_range(480, 2**OFF_W - 1));
          else if (sel < 4) b.req = OFF_W'($urandom_range(0, 200));
          else b.req = OFF_W'($urandom_range(1, 48));
        end
      end while (!try_beat(b, r));
      note_beat(b, r);
      send_beat(b, r);
      if (!(b.op == OPC_FREE && b.addr < HDR_BYTES)) useful++;
    end

    idle_on = 1'b0;
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("run covered %0d result beats: %0d allocates (%0d with no fit), %0d frees",
             replies_seen, n_alloc, n_nofit, n_free);
    $display("plus %0d frees below the header and %0d late stale-free attempts",
             n_ignored, n_stale);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("timeout with %0d results outstanding", reply_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_dp.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_top.sv
verif/testbench.sv
